[hw/rtl/plvs_pkg.sv]
// Shared types and constants for the perpendicular lattice vector search.
`timescale 1ns / 1ps
package plvs_pkg;

    localparam int IDX_W  = 4;   // Miller index width, two's complement
    localparam int COMP_W = 5;   // vector component width, two's complement
    localparam int BND_W  = 4;   // search bound, up to 14
    localparam int NRM_W  = 10;  // squared length, up to 3 * 14 * 14
    localparam int N_W    = 8;   // h*h + k*k + l*l, up to 192
    localparam int SQ_W   = 9;   // running square in the root search
    localparam int DOT_W  = 11;  // dot products, up to 3 * 14 * 14 in magnitude
    localparam int VEC_W  = 3 * COMP_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // capture the index triple, start the root search
        logic sqrt_step;    // advance the root search by one
        logic scan_start;   // set up a scan over the cube
        logic scan_second;  // the scan being started is the second one
        logic out_load;     // load the result register
        logic found;        // found flag for the result being loaded
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic zero_in;      // all three indices are zero
        logic sqrt_done;    // root search has settled
        logic scan_busy;    // scan counters or compare stage still active
        logic have_cand;    // the last scan found a candidate
    } dp_status_t;

    // One result item, found in the lowest bit
    typedef struct packed {
        logic signed [COMP_W-1:0] second_w;
        logic signed [COMP_W-1:0] second_v;
        logic signed [COMP_W-1:0] second_u;
        logic signed [COMP_W-1:0] first_w;
        logic signed [COMP_W-1:0] first_v;
        logic signed [COMP_W-1:0] first_u;
        logic                     found;
    } result_t;

endpackage

[hw/rtl/plvs_datapath.sv]
// Datapath: root search, cube scan counters, candidate test and result register.
`timescale 1ns / 1ps
module plvs_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic signed [plvs_pkg::IDX_W-1:0]      in_h,
    input  logic signed [plvs_pkg::IDX_W-1:0]      in_k,
    input  logic signed [plvs_pkg::IDX_W-1:0]      in_l,
    input  plvs_pkg::dp_cmd_t                      cmd,
    output plvs_pkg::dp_status_t                   status,
    output plvs_pkg::result_t                      result
);

    localparam int CW = plvs_pkg::COMP_W;
    localparam int DW = plvs_pkg::DOT_W;

    logic signed [plvs_pkg::IDX_W-1:0] h_reg, k_reg, l_reg;
    logic [plvs_pkg::N_W-1:0]          n_reg;
    logic [plvs_pkg::BND_W-1:0]        root_reg;
    logic [plvs_pkg::SQ_W-1:0]         sq_reg;
    logic [plvs_pkg::BND_W-1:0]        bound_reg;
    logic signed [CW-1:0]              u_reg, v_reg, w_reg;
    logic                              active_reg;
    logic                              second_reg;
    logic                              pipe_valid_reg;
    logic                              cand_ok_reg;
    logic [plvs_pkg::NRM_W-1:0]        cand_nrm_reg;
    logic [plvs_pkg::VEC_W-1:0]        cand_vec_reg;
    logic                              have_reg;
    logic [plvs_pkg::NRM_W-1:0]        best_norm_reg;
    logic [plvs_pkg::VEC_W-1:0]        best_first_reg;
    logic [plvs_pkg::VEC_W-1:0]        best_second_reg;
    plvs_pkg::result_t                 result_reg;

    logic [2*plvs_pkg::IDX_W-1:0]      sq_h, sq_k, sq_l;
    logic [plvs_pkg::N_W-1:0]          n_in;
    logic signed [CW-1:0]              bnd_pos, bnd_neg;
    logic signed [CW-1:0]              start_neg;
    logic signed [DW-1:0]              ue, ve, we, he, ke, le, pu, pv, pw;
    logic signed [2*DW-1:0]            m_uh, m_vk, m_wl, m_up, m_vp, m_wp;
    logic signed [2*DW-1:0]            m_uu, m_vv, m_ww;
    logic [DW-1:0]                     dot_hkl, dot_prev;
    logic [plvs_pkg::NRM_W-1:0]        nrm;
    logic                              last_vec;
    logic                              take;

    // Squared length of the incoming index triple
    always_comb begin
        sq_h = 8'($signed(in_h) * $signed(in_h));
        sq_k = 8'($signed(in_k) * $signed(in_k));
        sq_l = 8'($signed(in_l) * $signed(in_l));
        n_in = sq_h + sq_k + sq_l;
    end

    assign bnd_pos   = CW'({1'b0, bound_reg});
    assign bnd_neg   = -bnd_pos;
    assign start_neg = -(CW'({1'b0, root_reg}) + CW'(1));
    assign last_vec  = (u_reg == bnd_pos) && (v_reg == bnd_pos) && (w_reg == bnd_pos);

    // Candidate test operands, sign-extended to the dot product width
    always_comb begin
        ue = {{(DW-CW){u_reg[CW-1]}}, u_reg};
        ve = {{(DW-CW){v_reg[CW-1]}}, v_reg};
        we = {{(DW-CW){w_reg[CW-1]}}, w_reg};
        he = {{(DW-plvs_pkg::IDX_W){h_reg[plvs_pkg::IDX_W-1]}}, h_reg};
        ke = {{(DW-plvs_pkg::IDX_W){k_reg[plvs_pkg::IDX_W-1]}}, k_reg};
        le = {{(DW-plvs_pkg::IDX_W){l_reg[plvs_pkg::IDX_W-1]}}, l_reg};
        if (second_reg) begin
            pu = {{(DW-CW){best_first_reg[3*CW-1]}}, best_first_reg[3*CW-1:2*CW]};
            pv = {{(DW-CW){best_first_reg[2*CW-1]}}, best_first_reg[2*CW-1:CW]};
            pw = {{(DW-CW){best_first_reg[CW-1]}}, best_first_reg[CW-1:0]};
        end else begin
            pu = '0;
            pv = '0;
            pw = '0;
        end
        m_uh = ue * he;
        m_vk = ve * ke;
        m_wl = we * le;
        m_up = ue * pu;
        m_vp = ve * pv;
        m_wp = we * pw;
        m_uu = ue * ue;
        m_vv = ve * ve;
        m_ww = we * we;
        dot_hkl  = m_uh[DW-1:0] + m_vk[DW-1:0] + m_wl[DW-1:0];
        dot_prev = m_up[DW-1:0] + m_vp[DW-1:0] + m_wp[DW-1:0];
        nrm      = m_uu[plvs_pkg::NRM_W-1:0] + m_vv[plvs_pkg::NRM_W-1:0]
                 + m_ww[plvs_pkg::NRM_W-1:0];
    end

    assign take = pipe_valid_reg && cand_ok_reg && (!have_reg || cand_nrm_reg < best_norm_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            pipe_valid_reg <= 1'b0;
            have_reg       <= 1'b0;
            second_reg     <= 1'b0;
        end else begin
            if (cmd.load) begin
                h_reg    <= in_h;
                k_reg    <= in_k;
                l_reg    <= in_l;
                n_reg    <= n_in;
                root_reg <= '0;
                sq_reg   <= plvs_pkg::SQ_W'(1);
            end
            if (cmd.sqrt_step) begin
                // next square (r+2)^2 = (r+1)^2 + 2r + 3
                root_reg <= root_reg + plvs_pkg::BND_W'(1);
                sq_reg   <= sq_reg + plvs_pkg::SQ_W'({root_reg, 1'b1}) + plvs_pkg::SQ_W'(2);
            end

            // scan counters, w fastest
            pipe_valid_reg <= active_reg;
            if (cmd.scan_start) begin
                bound_reg     <= root_reg + plvs_pkg::BND_W'(1);
                u_reg         <= start_neg;
                v_reg         <= start_neg;
                w_reg         <= start_neg;
                active_reg    <= 1'b1;
                second_reg    <= cmd.scan_second;
                have_reg      <= 1'b0;
                best_norm_reg <= '0;
                if (cmd.scan_second) begin
                    best_second_reg <= '0;
                end else begin
                    best_first_reg <= '0;
                end
            end else if (active_reg) begin
                if (last_vec) begin
                    active_reg <= 1'b0;
                end else if (w_reg != bnd_pos) begin
                    w_reg <= w_reg + CW'(1);
                end else begin
                    w_reg <= bnd_neg;
                    if (v_reg != bnd_pos) begin
                        v_reg <= v_reg + CW'(1);
                    end else begin
                        v_reg <= bnd_neg;
                        u_reg <= u_reg + CW'(1);
                    end
                end
            end

            // compare stage: keep the first shortest candidate
            if (take) begin
                have_reg      <= 1'b1;
                best_norm_reg <= cand_nrm_reg;
                if (second_reg) begin
                    best_second_reg <= cand_vec_reg;
                end else begin
                    best_first_reg <= cand_vec_reg;
                end
            end
        end
    end

    // candidate stage and result register carry no reset
    always_ff @(posedge aclk) begin
        cand_ok_reg  <= (nrm != '0) && (dot_hkl == '0) && (dot_prev == '0);
        cand_nrm_reg <= nrm;
        cand_vec_reg <= {u_reg, v_reg, w_reg};
        if (cmd.out_load) begin
            result_reg.found <= cmd.found;
            if (cmd.found) begin
                result_reg.first_u  <= best_first_reg[3*CW-1:2*CW];
                result_reg.first_v  <= best_first_reg[2*CW-1:CW];
                result_reg.first_w  <= best_first_reg[CW-1:0];
                result_reg.second_u <= best_second_reg[3*CW-1:2*CW];
                result_reg.second_v <= best_second_reg[2*CW-1:CW];
                result_reg.second_w <= best_second_reg[CW-1:0];
            end else begin
                result_reg.first_u  <= '0;
                result_reg.first_v  <= '0;
                result_reg.first_w  <= '0;
                result_reg.second_u <= '0;
                result_reg.second_v <= '0;
                result_reg.second_w <= '0;
            end
        end
    end

    assign status.zero_in   = (h_reg == '0) && (k_reg == '0) && (l_reg == '0);
    assign status.sqrt_done = sq_reg > plvs_pkg::SQ_W'(n_reg);
    assign status.scan_busy = active_reg || pipe_valid_reg;
    assign status.have_cand = have_reg;
    assign result           = result_reg;

endmodule

[hw/rtl/plvs_ctrl.sv]
// Controller: sequences root search, up to two scans and the result handoff.
`timescale 1ns / 1ps
module plvs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  plvs_pkg::dp_status_t status,
    output plvs_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_SCAN1,
        ST_SCAN2,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   found_reg, found_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        found_next   = found_reg;
        cmd          = '0;
        cmd.found    = found_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (status.zero_in) begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end else if (status.sqrt_done) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN1;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            ST_SCAN1: begin
                if (!status.scan_busy) begin
                    if (status.have_cand) begin
                        cmd.scan_start  = 1'b1;
                        cmd.scan_second = 1'b1;
                        state_next      = ST_SCAN2;
                    end else begin
                        found_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN2: begin
                if (!status.scan_busy) begin
                    found_next = status.have_cand;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

[hw/rtl/perpendicular_lattice_vector_search.sv]
// Top level of the perpendicular lattice vector search block.
`timescale 1ns / 1ps
// Takes one Miller index triple (h,k,l) per item and returns one result item:
// the first shortest nonzero integer vector perpendicular to hkl and the first
// shortest vector perpendicular to both hkl and that vector, with found set
// when both exist. An all-zero triple, or a scan that finds nothing, returns
// found = 0 and all vector fields zero. Items are handled one at a time. With
// K = isqrt(h*h + k*k + l*l) + 1, an item runs a one-step-at-a-time root search
// that yields K, then two scans over the (2K+1)^3 points of the cube, one
// candidate per cycle through a two-stage test-and-compare path, then the
// result handoff. The scan counter that walks the cube dominates an item's
// running time. A finished result waits in the output register while the
// next item is already taken.
module perpendicular_lattice_vector_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // miller_h [3:0], miller_k [7:4], miller_l [11:8], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // found [0], first_u [5:1], first_v [10:6],
                                   // first_w [15:11], second_u [20:16],
                                   // second_v [25:21], second_w [30:26], zero [31]
);

    plvs_pkg::dp_cmd_t    cmd;
    plvs_pkg::dp_status_t status;
    plvs_pkg::result_t    result;

    logic signed [plvs_pkg::IDX_W-1:0] in_h, in_k, in_l;

    // unpack the input item
    assign in_h = s_tdata[3:0];
    assign in_k = s_tdata[7:4];
    assign in_l = s_tdata[11:8];

    plvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plvs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_h    (in_h),
        .in_k    (in_k),
        .in_l    (in_l),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    // found in the lowest bit, pad the top bit
    assign m_tdata = {1'b0, result};

    // Never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while held");

    // A failed search carries all-zero vectors
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[30:1] == '0))
        else $error("failure result with nonzero vector fields");

    // One item at a time: no new item right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous item in work");

    // A scan is only started once the previous one has drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> !status.scan_busy)
        else $error("scan started while scan still busy");

endmodule
